FILE: rtl/rpgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reverse palette gray mapper package
// Shared constants, register map and stage flag type for the mapper and its
// port checker.
// ----------------------------------------------------------------------------
package rpgm_pkg;

    // Default number of palette slots built into the block.
    localparam int PALETTE_DEPTH_DEF = 256;

    // Match vector is reduced in groups of this many slots.
    localparam int GROUP_W = 16;
    localparam int GROUP_SEL_W = 4;

    // Register map, word index on paddr[3:2].
    localparam int        APB_ADDR_W    = 4;
    localparam logic [1:0] REG_SIZE     = 2'd0;
    localparam logic [1:0] REG_BKGND    = 2'd1;
    localparam logic [1:0] REG_START    = 2'd2;
    localparam logic [1:0] REG_SLOPE    = 2'd3;

    // Register reset values.
    localparam logic [8:0]  SIZE_RESET  = 9'd256;
    localparam logic [31:0] BKGND_RESET = 32'h0000_0000;
    localparam logic [31:0] START_RESET = 32'h0000_0000;
    localparam logic [31:0] SLOPE_RESET = 32'h0001_0000;

    // Stream widths.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    // Full white gray level.
    localparam logic [7:0] GRAY_WHITE = 8'd255;

    // Input tuser codes.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    // Flags carried along the pipeline with each pixel.
    typedef struct packed {
        logic bg;
        logic hit;
    } stg_flags_t;

endpackage

FILE: rtl/reverse_palette_gray_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reverse palette gray mapper core
// Looks each pixel up in a loaded palette and maps the first matching index
// through a clamped Q16.16 ramp to an 8-bit gray level.
// ----------------------------------------------------------------------------
// An accepted pixel beat passes the compare, group, select, multiply, clamp, scale,
// divider and output registers. Palette writes produce no result beat.
// Throughput: one beat per cycle unless m_tready stalls; the full-width palette
// compare and two-bit-per-stage divider are pipelined, so nothing recirculates.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the
// registers; palette contents are left as they were and must be reloaded.
// ----------------------------------------------------------------------------
module reverse_palette_gray_mapper_core #(
    parameter int PALETTE_DEPTH = rpgm_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Slave side input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: entry_index [7:0], entry_value [39:8], pixel [71:40]
    input  logic [rpgm_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: action [0] (0 writes a palette entry, 1 converts a pixel)
    input  logic [0:0]                      s_tuser,

    // Master side result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: gray [7:0]
    output logic [rpgm_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: palette_hit [0]
    output logic [0:0]                      m_tuser,

    // APB configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpgm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // Width of an index that can also hold PALETTE_DEPTH itself.
    localparam int M_W     = $clog2(PALETTE_DEPTH + 1);
    // Match vector grouping for the two-level first-hit search.
    localparam int GRP_N   = (PALETTE_DEPTH + rpgm_pkg::GROUP_W - 1) / rpgm_pkg::GROUP_W;
    localparam int PAD_W   = GRP_N * rpgm_pkg::GROUP_W;
    // Product of index and slope, and the sum with the start offset.
    localparam int MUL_W   = M_W + 33;
    localparam int SUM_W   = M_W + 34;
    // Clamped ramp value x, between 0 and n in Q16.16.
    localparam int X_W     = M_W + 16;
    // Integer part of 255 * x, the dividend of the divider.
    localparam int REM_W   = M_W + 8;
    localparam int DIV_STG = 4;

    // ------------------------------------------------------------------
    // Configuration registers. The APB port never waits.
    // ------------------------------------------------------------------
    logic [8:0]  palette_size_reg;
    logic [31:0] background_value_reg;
    logic [31:0] ramp_start_reg;
    logic [31:0] ramp_slope_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg     <= rpgm_pkg::SIZE_RESET;
            background_value_reg <= rpgm_pkg::BKGND_RESET;
            ramp_start_reg       <= rpgm_pkg::START_RESET;
            ramp_slope_reg       <= rpgm_pkg::SLOPE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rpgm_pkg::REG_SIZE:  palette_size_reg     <= pwdata[8:0];
                rpgm_pkg::REG_BKGND: background_value_reg <= pwdata;
                rpgm_pkg::REG_START: ramp_start_reg       <= pwdata;
                rpgm_pkg::REG_SLOPE: ramp_slope_reg       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rpgm_pkg::REG_SIZE:  prdata = {23'd0, palette_size_reg};
            rpgm_pkg::REG_BKGND: prdata = background_value_reg;
            rpgm_pkg::REG_START: prdata = ramp_start_reg;
            rpgm_pkg::REG_SLOPE: prdata = ramp_slope_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // The active size n is the programmed size forced into 1..PALETTE_DEPTH.
    // Every stage uses it directly, so the user must change registers only while
    // the pipeline is empty; the block itself does not enforce this.
    logic [M_W-1:0] n_act;

    always_comb
    begin
        if (palette_size_reg == 9'd0)
            n_act = M_W'(1);
        else if (32'(palette_size_reg) > 32'(PALETTE_DEPTH))
            n_act = M_W'(PALETTE_DEPTH);
        else
            n_act = M_W'(palette_size_reg);
    end

    // ------------------------------------------------------------------
    // Input beat fields.
    // ------------------------------------------------------------------
    logic [7:0]  in_entry_index;
    logic [31:0] in_entry_value;
    logic [31:0] in_pixel;
    logic        in_accept;
    logic        pal_wr;

    assign in_entry_index = s_tdata[7:0];
    assign in_entry_value = s_tdata[39:8];
    assign in_pixel       = s_tdata[71:40];
    assign in_accept      = s_tvalid && s_tready;
    // Writes to slots past the built depth are dropped.
    assign pal_wr         = in_accept && (s_tuser[0] == rpgm_pkg::ACT_WRITE) &&
                            (32'(in_entry_index) < 32'(PALETTE_DEPTH));

    // ------------------------------------------------------------------
    // Palette storage. Every slot has its own comparator, so the slots are
    // kept in flip-flops and each one is read only by its own compare.
    // ------------------------------------------------------------------
    logic [31:0] palette_reg [PALETTE_DEPTH];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            if (pal_wr && (32'(in_entry_index) == 32'(i)))
                palette_reg[i] <= in_entry_value;
        end
    end

    // ------------------------------------------------------------------
    // Ready chain. A stage takes a new beat when it is empty or when its
    // content moves on, so bubbles collapse and the output register lets
    // the input keep flowing while a result waits.
    // ------------------------------------------------------------------
    logic cmp_valid_reg, grp_valid_reg, sel_valid_reg;
    logic mul_valid_reg, clp_valid_reg, scl_valid_reg, out_valid_reg;
    logic [DIV_STG-1:0] div_valid_reg;

    logic cmp_ready, grp_ready, sel_ready, mul_ready, clp_ready, scl_ready, out_ready;
    logic [DIV_STG-1:0] div_ready;

    assign out_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        div_ready[DIV_STG-1] = !div_valid_reg[DIV_STG-1] || out_ready;
        for (int j = DIV_STG - 2; j >= 0; j--)
            div_ready[j] = !div_valid_reg[j] || div_ready[j+1];
    end

    assign scl_ready = !scl_valid_reg || div_ready[0];
    assign clp_ready = !clp_valid_reg || scl_ready;
    assign mul_ready = !mul_valid_reg || clp_ready;
    assign sel_ready = !sel_valid_reg || mul_ready;
    assign grp_ready = !grp_valid_reg || sel_ready;
    assign cmp_ready = !cmp_valid_reg || grp_ready;
    assign s_tready  = cmp_ready;

    // ------------------------------------------------------------------
    // Stage 1: compare the pixel against every active slot and against the
    // background value. Slots at or beyond n never count as a match.
    // ------------------------------------------------------------------
    logic [PAD_W-1:0]     match_next;
    logic [PAD_W-1:0]     cmp_match_reg;
    logic                 cmp_bg_reg;

    always_comb
    begin
        match_next = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            match_next[i] = (palette_reg[i] == in_pixel) && (32'(i) < 32'(n_act));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_valid_reg <= 1'b0;
        else if (cmp_ready)
            cmp_valid_reg <= s_tvalid && (s_tuser[0] == rpgm_pkg::ACT_CONVERT);
    end

    always_ff @(posedge clk)
    begin
        if (cmp_ready)
        begin
            cmp_match_reg <= match_next;
            cmp_bg_reg    <= (in_pixel == background_value_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first hit inside each group of slots.
    // ------------------------------------------------------------------
    logic [GRP_N-1:0]                   grp_hit_next;
    logic [rpgm_pkg::GROUP_SEL_W-1:0]   grp_pos_next [GRP_N];
    logic [GRP_N-1:0]                   grp_hit_reg;
    logic [rpgm_pkg::GROUP_SEL_W-1:0]   grp_pos_reg  [GRP_N];
    logic                               grp_bg_reg;

    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_pos_next[g] = '0;
            for (int b = rpgm_pkg::GROUP_W - 1; b >= 0; b--)
            begin
                if (cmp_match_reg[g * rpgm_pkg::GROUP_W + b])
                begin
                    grp_hit_next[g] = 1'b1;
                    grp_pos_next[g] = rpgm_pkg::GROUP_SEL_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grp_valid_reg <= 1'b0;
        else if (grp_ready)
            grp_valid_reg <= cmp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (grp_ready)
        begin
            grp_hit_reg <= grp_hit_next;
            grp_pos_reg <= grp_pos_next;
            grp_bg_reg  <= cmp_bg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first group with a hit gives m; no hit gives m = n.
    // ------------------------------------------------------------------
    logic [M_W-1:0]       m_next;
    logic                 found_next;
    logic [M_W-1:0]       sel_m_reg;
    rpgm_pkg::stg_flags_t sel_flags_reg;

    always_comb
    begin
        found_next = 1'b0;
        m_next     = n_act;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                found_next = 1'b1;
                m_next     = M_W'(32'(g) * 32'(rpgm_pkg::GROUP_W) + 32'(grp_pos_reg[g]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else if (sel_ready)
            sel_valid_reg <= grp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sel_ready)
        begin
            sel_m_reg         <= m_next;
            sel_flags_reg.bg  <= grp_bg_reg;
            sel_flags_reg.hit <= grp_bg_reg || found_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: m * slope. The index is unsigned, so it enters the signed
    // multiply with a zero sign bit.
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0] mul_prod_reg;
    rpgm_pkg::stg_flags_t    mul_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_ready)
            mul_valid_reg <= sel_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready)
        begin
            mul_prod_reg  <= $signed({1'b0, sel_m_reg}) * $signed(ramp_slope_reg);
            mul_flags_reg <= sel_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the start offset and clamp to [0, n] in Q16.16.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] ramp_sum;
    logic signed [SUM_W-1:0] ceil_s;
    logic [X_W-1:0]          ceil_q;
    logic [X_W-1:0]          x_next;
    logic [X_W-1:0]          clp_x_reg;
    rpgm_pkg::stg_flags_t    clp_flags_reg;

    always_comb
    begin
        ceil_q   = {n_act, 16'h0000};
        ceil_s   = $signed(SUM_W'(ceil_q));
        ramp_sum = SUM_W'(mul_prod_reg) + SUM_W'($signed(ramp_start_reg));
        if (ramp_sum < 0)
            x_next = '0;
        else if (ramp_sum > ceil_s)
            x_next = ceil_q;
        else
            x_next = ramp_sum[X_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clp_valid_reg <= 1'b0;
        else if (clp_ready)
            clp_valid_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (clp_ready)
        begin
            clp_x_reg     <= x_next;
            clp_flags_reg <= mul_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: 255 * x. The divisor is n * 65536, so the low 16 bits only
    // decide whether the quotient rounds up; the divider sees the rest.
    // ------------------------------------------------------------------
    logic [X_W+7:0]       scaled;
    logic [REM_W-1:0]     scl_rem_reg;
    logic                 scl_frac_reg;
    rpgm_pkg::stg_flags_t scl_flags_reg;

    assign scaled = {clp_x_reg, 8'h00} - (X_W+8)'(clp_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scl_valid_reg <= 1'b0;
        else if (scl_ready)
            scl_valid_reg <= clp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (scl_ready)
        begin
            scl_rem_reg   <= scaled[X_W+7:16];
            scl_frac_reg  <= |scaled[15:0];
            scl_flags_reg <= clp_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 7 to 10: restoring division by n, two quotient bits a stage,
    // most significant first. The dividend is below 256 * n, so eight
    // quotient bits suffice.
    // ------------------------------------------------------------------
    logic [REM_W-1:0]     div_rem_reg   [DIV_STG];
    logic [7:0]           div_q_reg     [DIV_STG];
    logic                 div_frac_reg  [DIV_STG];
    rpgm_pkg::stg_flags_t div_flags_reg [DIV_STG];

    logic [REM_W-1:0]     div_rem_next  [DIV_STG];
    logic [7:0]           div_q_next    [DIV_STG];
    logic [REM_W-1:0]     div_rem_in    [DIV_STG];
    logic [7:0]           div_q_in      [DIV_STG];
    logic [REM_W-1:0]     div_sub;

    always_comb
    begin
        div_sub = '0;
        for (int j = 0; j < DIV_STG; j++)
        begin
            if (j == 0)
            begin
                div_rem_in[j] = scl_rem_reg;
                div_q_in[j]   = 8'd0;
            end
            else
            begin
                div_rem_in[j] = div_rem_reg[j-1];
                div_q_in[j]   = div_q_reg[j-1];
            end
            div_rem_next[j] = div_rem_in[j];
            div_q_next[j]   = div_q_in[j];
            for (int k = 7 - 2 * j; k >= 6 - 2 * j; k--)
            begin
                div_sub = REM_W'(n_act) << k;
                if (div_rem_next[j] >= div_sub)
                begin
                    div_rem_next[j] = div_rem_next[j] - div_sub;
                    div_q_next[j][k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_valid_reg <= '0;
        else
        begin
            for (int j = 0; j < DIV_STG; j++)
            begin
                if (div_ready[j])
                    div_valid_reg[j] <= (j == 0) ? scl_valid_reg : div_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STG; j++)
        begin
            if (div_ready[j])
            begin
                div_rem_reg[j]   <= div_rem_next[j];
                div_q_reg[j]     <= div_q_next[j];
                div_frac_reg[j]  <= (j == 0) ? scl_frac_reg  : div_frac_reg[j-1];
                div_flags_reg[j] <= (j == 0) ? scl_flags_reg : div_flags_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: round the quotient up when anything was left over and turn
    // it into a gray level. The rounded quotient never exceeds 255.
    // Background pixels bypass the ramp.
    // ------------------------------------------------------------------
    logic [8:0]  q_ceil;
    logic [7:0]  gray_next;
    logic [7:0]  out_gray_reg;
    logic        out_hit_reg;

    always_comb
    begin
        q_ceil = {1'b0, div_q_reg[DIV_STG-1]} +
                 9'((div_rem_reg[DIV_STG-1] != '0) || div_frac_reg[DIV_STG-1]);
        if (div_flags_reg[DIV_STG-1].bg)
            gray_next = rpgm_pkg::GRAY_WHITE;
        else
            gray_next = rpgm_pkg::GRAY_WHITE - q_ceil[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= div_valid_reg[DIV_STG-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_gray_reg <= gray_next;
            out_hit_reg  <= div_flags_reg[DIV_STG-1].hit;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_gray_reg;
    assign m_tuser[0] = out_hit_reg;

endmodule

FILE: rtl/rpgm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reverse palette gray mapper port checker
// Watches the ports of the mapper core for stream and register misbehavior.
// ----------------------------------------------------------------------------
module rpgm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rpgm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [rpgm_pkg::APB_ADDR_W-1:0] paddr,
    input logic [31:0]                     pwdata,
    input logic [31:0]                     prdata,
    input logic                            pready
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The input only backs up when the whole pipeline is full behind a
    // blocked result.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result beat during reset");

    // A read of the background register right after a write to it returns the written value.
    a_bkgnd_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[3:2] == rpgm_pkg::REG_BKGND)
        |=> !(psel && !pwrite && (paddr[3:2] == rpgm_pkg::REG_BKGND)) ||
            (prdata == $past(pwdata)))
        else $error("background register readback mismatch");

endmodule

bind reverse_palette_gray_mapper_core rpgm_checker u_rpgm_checker (.*);

FILE: tb/sv/tb_reverse_palette_gray_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reverse palette gray mapper core testbench
// Loads the palette over the input stream, programs the ramp over APB and
// streams pixels through the core. Every result beat is checked field by
// field against a local predictor of the palette lookup and the ramp or a
// fixed result, under several register settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_reverse_palette_gray_mapper_core;

    localparam int DEPTH      = rpgm_pkg::PALETTE_DEPTH_DEF;
    // Idle wait after draining, long enough for a beat to cross the core's pipeline.
    localparam int DRAIN_WAIT = 16;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_BEATS = 70;

    // One expected result beat: the gray level and the palette hit flag.
    typedef struct packed {
        logic [7:0] gray;
        logic       hit;
    } gray_result_t;

    // A directed row either sends one input beat or writes one register.
    typedef enum logic [0:0] {
        ROW_BEAT = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    // For register rows, value carries the register data and reg_sel the
    // register. For conversion rows with known_res set, gray and hit hold
    // the expected result; otherwise the predictor supplies it.
    typedef struct packed {
        row_kind_t   kind;
        logic        act;
        logic [7:0]  slot;
        logic [31:0] value;
        logic [31:0] pix;
        logic [1:0]  reg_sel;
        logic        known_res;
        logic [7:0]  gray;
        logic        hit;
    } stim_row_t;

    localparam int NUM_ROWS = 31;

    // Directed stimulus. The palette is shrunk to four entries before any
    // pixel that needs a lookup, so that no unwritten slot is ever compared.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Background match straight out of reset, no palette lookup needed.
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h0000_0004, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'h01, 32'h0000_0001, 32'hFFFF_FFFF,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'h02, 32'h8000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'h03, 32'h1234_5678, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        // Highest slot, written with zero.
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'hFF, 32'h0000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        // Match at index zero sits at the bottom of the ramp.
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h1234_5678,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0001,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        // No match: the ramp is evaluated at the end of the palette.
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'hDEAD_BEEF,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_WRITE,   8'h03, 32'hDEAD_BEEF, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        // Converted right behind the overwrite of its slot.
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'hDEAD_BEEF,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000,
          rpgm_pkg::REG_BKGND, 1'b0, 8'd0,   1'b0},
        // Background wins over the palette entry at slot zero.
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd0,   1'b0},
        // Most negative offset clamps to white.
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h8000_0000, 32'h0000_0000,
          rpgm_pkg::REG_START, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h8000_0000,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        // Most positive offset clamps to black.
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h7FFF_FFFF, 32'h0000_0000,
          rpgm_pkg::REG_START, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0001,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd0,   1'b1},
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h0000_0000, 32'h0000_0000,
          rpgm_pkg::REG_START, 1'b0, 8'd0,   1'b0},
        // Slope extremes, in both directions.
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h8000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SLOPE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h8000_0000,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h7FFF_FFFF, 32'h0000_0000,
          rpgm_pkg::REG_SLOPE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0001,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd0,   1'b1},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF,
          rpgm_pkg::REG_SIZE, 1'b1, 8'd255, 1'b1},
        // A fractional slope lands the ramp between gray steps.
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h0000_8000, 32'h0000_0000,
          rpgm_pkg::REG_SLOPE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'hDEAD_BEEF,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        // A size of zero behaves as a one-entry palette.
        '{ROW_REG,  rpgm_pkg::ACT_WRITE,   8'h00, 32'h0000_0000, 32'h0000_0000,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h0000_0001,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0},
        '{ROW_BEAT, rpgm_pkg::ACT_CONVERT, 8'h00, 32'h0000_0000, 32'h1234_5678,
          rpgm_pkg::REG_SIZE, 1'b0, 8'd0,   1'b0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // tdata: entry_index [7:0], entry_value [39:8], pixel [71:40]
    logic [rpgm_pkg::IN_DATA_W-1:0]  s_tdata;
    // tuser: action [0]
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // tdata: gray [7:0]
    logic [rpgm_pkg::OUT_DATA_W-1:0] m_tdata;
    // tuser: palette_hit [0]
    logic [0:0]                      m_tuser;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rpgm_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // Local copy of the palette and registers, updated as beats and register
    // writes are accepted by the core.
    logic [31:0]        pal_mirror [DEPTH];
    logic [8:0]         size_q;
    logic [31:0]        bg_q;
    logic signed [31:0] start_q;
    logic signed [31:0] slope_q;

    // A handful of shared values so that duplicate palette entries, and
    // backgrounds that also sit in the palette, come up often.
    logic [31:0]        value_pool [8];

    gray_result_t       pending_grays [$];
    int                 mismatch_count;
    int                 sender_idle_pct;
    int                 recv_stall_pct;

    reverse_palette_gray_mapper_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Number of palette entries searched: the size register limited to the
    // range one to the palette depth.
    function automatic int unsigned active_count();
        if (size_q == 9'd0)
        begin
            return 1;
        end
        if (size_q > DEPTH)
        begin
            return DEPTH;
        end
        return 32'(size_q);
    endfunction

    // Gray level for one pixel under the current palette and registers. The
    // ramp position x is in Q16.16 and clamped to [0, n]; the gray level is
    // 255 minus the ceiling of 255 * x / n, done in exact integer arithmetic.
    function automatic gray_result_t predict_gray(input logic [31:0] pix);
        gray_result_t res;
        int unsigned  n;
        int unsigned  m;
        longint       x;
        longint       ceiling;
        longint       q;
        if (pix == bg_q)
        begin
            res.gray = rpgm_pkg::GRAY_WHITE;
            res.hit  = 1'b1;
            return res;
        end
        n = active_count();
        m = 0;
        while (m < n && pal_mirror[m] != pix)
        begin
            m++;
        end
        res.hit = (m < n);
        x = longint'(start_q) + longint'(m) * longint'(slope_q);
        ceiling = longint'(n) * 65536;
        if (x < 0)
        begin
            x = 0;
        end
        if (x > ceiling)
        begin
            x = ceiling;
        end
        q = (255 * x + ceiling - 1) / ceiling;
        if (q > 255)
        begin
            q = 255;
        end
        res.gray = 8'(255 - q);
        return res;
    endfunction

    // Palette entry value: a shared value one time in four, else random.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0)
        begin
            return value_pool[$urandom_range(7)];
        end
        return $urandom();
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Sends one input beat, with random idle cycles in front of it when the
    // sender is set to idle. Called at a rising edge; returns at the edge at
    // which the beat was accepted, leaving tvalid high so that back-to-back
    // beats need no extra assignment. The expected result is queued at
    // acceptance, so palette writes and pixels are predicted in stream order.
    task automatic send_beat(input logic act, input logic [7:0] slot,
                             input logic [31:0] value, input logic [31:0] pix,
                             input logic known_res, input gray_result_t fixed_res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {pix, value, slot};
        do
            @(posedge clk);
        while (!s_tready);
        if (act == rpgm_pkg::ACT_WRITE)
        begin
            pal_mirror[slot] = value;
        end
        else
        begin
            pending_grays.push_back(known_res ? fixed_res : predict_gray(pix));
        end
    endtask

    // Brings the core to rest: stops sending, waits for every expected beat
    // and then lets the pipeline settle, since palette writes leave no beat
    // behind that could be waited for.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_grays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // APB write: setup phase, then access phase until pready, then an idle phase
    // so that the next transfer starts from a deselected bus.
    task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            rpgm_pkg::REG_SIZE:  size_q  = value[8:0];
            rpgm_pkg::REG_BKGND: bg_q    = value;
            rpgm_pkg::REG_START: start_q = value;
            rpgm_pkg::REG_SLOPE: slope_q = value;
            default:   ;
        endcase
        @(posedge clk);
    endtask

    // Result checker and receiver stalls. Each accepted result beat is
    // compared with the oldest expectation; tready is redrawn every cycle
    // from the current stall rate.
    always @(posedge clk)
    begin : result_check
        gray_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_grays.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result beat gray=%0d hit=%0d",
                                       m_tdata, m_tuser[0]));
            end
            else
            begin
                want = pending_grays.pop_front();
                if (m_tdata !== want.gray || m_tuser[0] !== want.hit)
                begin
                    log_mismatch($sformatf("expected gray=%0d hit=%0d, got gray=%0d hit=%0d",
                                           want.gray, want.hit, m_tdata, m_tuser[0]));
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int           phase;
        int           k;
        int           r;
        int unsigned  n;
        logic [8:0]   size_val;
        logic [31:0]  start_val;
        logic [31:0]  slope_val;
        logic [31:0]  bg_val;
        gray_result_t fixed_res;

        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = rpgm_pkg::ACT_WRITE;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        size_q          = rpgm_pkg::SIZE_RESET;
        bg_q            = rpgm_pkg::BKGND_RESET;
        start_q         = rpgm_pkg::START_RESET;
        slope_q         = rpgm_pkg::SLOPE_RESET;
        for (k = 0; k < DEPTH; k++)
        begin
            pal_mirror[k] = '0;
        end
        for (k = 0; k < 8; k++)
        begin
            value_pool[k] = $urandom();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side.
        for (k = 0; k < NUM_ROWS; k++)
        begin
            if (DIRECTED_ROWS[k].kind == ROW_REG)
            begin
                drain_pipe();
                write_reg(DIRECTED_ROWS[k].reg_sel, DIRECTED_ROWS[k].value);
            end
            else
            begin
                fixed_res.gray = DIRECTED_ROWS[k].gray;
                fixed_res.hit  = DIRECTED_ROWS[k].hit;
                send_beat(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].slot,
                          DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].pix,
                          DIRECTED_ROWS[k].known_res, fixed_res);
            end
        end

        // Fill every slot, so that any active size can be searched safely
        // from here on. Pixel bits ride along as noise.
        fixed_res = '0;
        for (k = 0; k < DEPTH; k++)
        begin
            send_beat(rpgm_pkg::ACT_WRITE, 8'(k), pick_value(), $urandom(), 1'b0,
                      fixed_res);
        end

        // Random phases. Each one reprograms all four registers, with the
        // extremes of the size register early on, and then streams a mix of
        // palette writes, background pixels, palette hits and random pixels.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipe();
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 64;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 64;
                end
                default:
                begin
                    sender_idle_pct = 34;
                    recv_stall_pct  = 34;
                end
            endcase

            case (phase)
                0:       size_val = 9'd256;
                1:       size_val = 9'd511;
                2:       size_val = 9'd1;
                3:       size_val = 9'd0;
                4:       size_val = 9'd16;
                5:       size_val = 9'd300;
                default: size_val = 9'($urandom_range(1, DEPTH));
            endcase
            write_reg(rpgm_pkg::REG_SIZE, {23'd0, size_val});
            n = active_count();

            // Ramp offset and slope: mostly in a range where the gray level
            // spreads over the palette, sometimes at the extremes.
            case ($urandom_range(7))
                0:       start_val = 32'h0000_0000;
                1:       start_val = 32'h8000_0000;
                2:       start_val = 32'h7FFF_FFFF;
                default: start_val = 32'($urandom_range(2 * n * 65536)) - 32'(n * 65536);
            endcase
            case ($urandom_range(7))
                0:       slope_val = 32'h0001_0000;
                1:       slope_val = 32'h8000_0000;
                2:       slope_val = 32'h7FFF_FFFF;
                3:       slope_val = 32'h0000_0000;
                default: slope_val = 32'($urandom_range(4 * 65536)) - 32'(2 * 65536);
            endcase
            bg_val = ($urandom_range(1) == 0) ? pal_mirror[$urandom_range(n - 1)]
                                              : $urandom();
            write_reg(rpgm_pkg::REG_START, start_val);
            write_reg(rpgm_pkg::REG_SLOPE, slope_val);
            write_reg(rpgm_pkg::REG_BKGND, bg_val);

            for (k = 0; k < PHASE_BEATS; k++)
            begin
                r = $urandom_range(99);
                if (r < 12)
                begin
                    send_beat(rpgm_pkg::ACT_WRITE, 8'($urandom_range(DEPTH - 1)),
                              pick_value(), $urandom(), 1'b0, fixed_res);
                end
                else if (r < 22)
                begin
                    send_beat(rpgm_pkg::ACT_CONVERT, 8'($urandom()), $urandom(), bg_q,
                              1'b0, fixed_res);
                end
                else if (r < 72)
                begin
                    send_beat(rpgm_pkg::ACT_CONVERT, 8'($urandom()), $urandom(),
                              pal_mirror[$urandom_range(n - 1)], 1'b0, fixed_res);
                end
                else
                begin
                    send_beat(rpgm_pkg::ACT_CONVERT, 8'($urandom()), $urandom(),
                              pick_value(), 1'b0, fixed_res);
                end
            end
        end

        // Wind down: everything must come out, then nothing more may.
        drain_pipe();
        repeat (24) @(posedge clk);
        if (pending_grays.size() != 0)
        begin
            log_mismatch($sformatf("%0d result beats never arrived",
                                   pending_grays.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rpgm_pkg.sv
rtl/reverse_palette_gray_mapper_core.sv
rtl/rpgm_checker.sv
tb/sv/tb_reverse_palette_gray_mapper_core.sv
